### sv/itad_pkg.sv
// Package for the integer-to-ASCII digit converter.
// Holds field widths, ASCII codes and the digit-to-character mapping.
// No dependencies.
package itad_pkg;

    // Field widths
    localparam int VALUE_BITS_W = 64;
    localparam int CHAR_W       = 7;

    // Default number of significant value bits
    localparam int VALUE_WIDTH_DEF = 64;

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;

    // Map one digit (0..15) to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d,
                                                         input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (d < 4'd10) begin
            digit_to_ascii = ASCII_ZERO + CHAR_W'(d);
        end else begin
            digit_to_ascii = base + CHAR_W'(d - 4'd10);
        end
    endfunction

endpackage

### sv/itad_if.sv
// Channel interfaces for the integer-to-ASCII digit converter.
// itad_in_if carries one value beat, itad_out_if one character beat.
// Depends on itad_pkg.
interface itad_in_if;
    logic                             valid;
    logic                             ready;
    logic [itad_pkg::VALUE_BITS_W-1:0] value_bits;
    logic                             is_signed;
    logic                             hex;
    logic                             upper_case;

    modport source (output valid, output value_bits, output is_signed,
                    output hex, output upper_case, input ready);
    modport sink   (input valid, input value_bits, input is_signed,
                    input hex, input upper_case, output ready);
endinterface

interface itad_out_if;
    logic                       valid;
    logic                       ready;
    logic [itad_pkg::CHAR_W-1:0] char_code;
    logic                       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

### sv/integer_to_ascii_digits_top.sv
// Converter top level: bit-serial double dabble and digit shifter; uses itad_pkg, itad_if.
// Decimal: the magnitude is shifted into the BCD register bit by bit (ST_CONV), then a minus
// sign if negative (ST_SIGN), then digits from the top, leading zeros skipped (ST_EMIT).
// Unsigned hex goes straight to ST_EMIT. A new value is taken only in idle, after the last
// character of the one before has been issued; output stalls hold the sequencer.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and drops output valid.
module integer_to_ascii_digits_top #(
    parameter int VALUE_WIDTH = itad_pkg::VALUE_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    itad_in_if.sink        i_in,
    itad_out_if.source     o_out
);

    // Decimal digits needed for VALUE_WIDTH bits, and the digit register width
    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int DIGW  = NDIG * 4;
    localparam int BCW   = $clog2(VALUE_WIDTH + 1);
    localparam int DCW   = $clog2(NDIG + 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [VALUE_WIDTH-1:0]     r_bin, n_bin;
    logic [DIGW-1:0]            r_dig, n_dig;
    logic [BCW-1:0]             r_bit_cnt, n_bit_cnt;
    logic [DCW-1:0]             r_cnt, n_cnt;
    logic                       r_neg, n_neg;
    logic                       r_upper, n_upper;
    logic                       r_lead, n_lead;
    logic                       r_ovalid, n_ovalid;
    logic [itad_pkg::CHAR_W-1:0] r_char, n_char;
    logic                       r_last, n_last;

    logic                       in_beat;
    logic                       out_free;
    logic [VALUE_WIDTH-1:0]     in_val;
    logic [VALUE_WIDTH-1:0]     in_mag;
    logic                       in_neg;
    logic                       in_hex;
    logic [DIGW-1:0]            bcd_fix;
    logic [3:0]                 top_dig;

    assign i_in.ready      = (r_state == ST_IDLE);
    assign in_beat         = i_in.valid && i_in.ready;
    assign out_free        = !r_ovalid || o_out.ready;
    assign o_out.valid     = r_ovalid;
    assign o_out.char_code = r_char;
    assign o_out.last      = r_last;

    // Input decode: masked value, sign and magnitude
    assign in_val  = i_in.value_bits[VALUE_WIDTH-1:0];
    assign in_neg  = i_in.is_signed && in_val[VALUE_WIDTH-1];
    assign in_mag  = in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;
    assign in_hex  = i_in.hex && !i_in.is_signed;
    assign top_dig = r_dig[DIGW-1 -: 4];

    // Add-3 correction on every BCD digit ahead of the shift
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (r_dig[k*4 +: 4] >= 4'd5) begin
                bcd_fix[k*4 +: 4] = r_dig[k*4 +: 4] + 4'd3;
            end else begin
                bcd_fix[k*4 +: 4] = r_dig[k*4 +: 4];
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_dig     = r_dig;
        n_bit_cnt = r_bit_cnt;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_upper   = r_upper;
        n_lead    = r_lead;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_char    = r_char;
        n_last    = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_neg     = in_neg;
                    n_upper   = i_in.upper_case && in_hex;
                    n_lead    = 1'b1;
                    n_cnt     = DCW'(NDIG);
                    n_bin     = in_mag;
                    n_bit_cnt = BCW'(VALUE_WIDTH);
                    if (in_hex) begin
                        n_dig   = {{(DIGW-VALUE_WIDTH){1'b0}}, in_val};
                        n_state = ST_EMIT;
                    end else begin
                        n_dig   = '0;
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                // One value bit into the BCD register per cycle
                n_dig     = {bcd_fix[DIGW-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin     = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt - BCW'(1);
                if (r_bit_cnt == BCW'(1)) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = itad_pkg::ASCII_MINUS;
                    n_last   = 1'b0;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_lead && top_dig == 4'd0 && r_cnt != DCW'(1)) begin
                    // Drop a leading zero digit
                    n_dig = {r_dig[DIGW-5:0], 4'd0};
                    n_cnt = r_cnt - DCW'(1);
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = itad_pkg::digit_to_ascii(top_dig, r_upper);
                    n_last   = (r_cnt == DCW'(1));
                    n_lead   = 1'b0;
                    n_dig    = {r_dig[DIGW-5:0], 4'd0};
                    n_cnt    = r_cnt - DCW'(1);
                    if (r_cnt == DCW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_dig     <= n_dig;
        r_bit_cnt <= n_bit_cnt;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_upper   <= n_upper;
        r_lead    <= n_lead;
        r_char    <= n_char;
        r_last    <= n_last;
    end

`ifndef SYNTH
    // A stalled character beat must hold until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_char) && $stable(r_last)))
        else $error("output beat changed while stalled");

    // Conversion loop never runs with an exhausted bit count
    a_conv_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> (r_bit_cnt != '0))
        else $error("conversion bit count underflow");

    // Emission always has at least one digit left
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("digit count underflow");

    // A new value is never taken in the cycle after one was taken
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in.ready)
        else $error("second value accepted while busy");
`endif

endmodule
